>>> hw/rtl/assert_macros.svh
// Assertion helpers for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bpsr_pkg.sv
`default_nettype none

package bpsr_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_PATTERN_LOW      = 3'd0,
    REG_PATTERN_HIGH     = 3'd1,
    REG_REPLACEMENT_LOW  = 3'd2,
    REG_REPLACEMENT_HIGH = 3'd3,
    REG_PATTERN_LENGTH   = 3'd4,
    REG_REPLACE_ENABLE   = 3'd5
  } reg_index_e;

  localparam int unsigned CFG_INDEX_W  = 3;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned CFG_BYTES    = 16;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QUEUE_PTR_W  = 2;

  // One input beat as it sits in the queue.
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } item_t;

  // Settings the window engine needs.
  typedef struct packed {
    logic [8*CFG_BYTES-1:0] pattern;
    logic [8*CFG_BYTES-1:0] replacement;
    logic                   replace_en;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    logic        last;
    logic [31:0] total;
    logic        start;
    logic [31:0] position;
    logic [7:0]  data;
  } result_t;

  // Window engine states.
  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_FLUSH = 2'b10
  } bk_state_e;

endpackage

`default_nettype wire

>>> hw/rtl/bpsr_queue.sv
`default_nettype none

module bpsr_queue
  import bpsr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t push_item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       head_valid_o,
  output item_t      head_item_o
);

  item_t                   mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QUEUE_PTR_W:0]    count_q;

  assign full_o       = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bpsr_back.sv
`default_nettype none

module bpsr_back
  import bpsr_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned LW          = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cfg_t          cfg_i,
  input  wire logic [LW-1:0] len_i,
  input  wire logic          head_valid_i,
  input  wire item_t         head_item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output result_t            out_o
);

  logic [7:0]  win_q [MAX_PATTERN];
  logic [7:0]  win_d [MAX_PATTERN];
  logic [7:0]  cand  [MAX_PATTERN];
  logic [7:0]  full  [MAX_PATTERN];
  logic [7:0]  sh_win  [MAX_PATTERN];
  logic [7:0]  sh_full [MAX_PATTERN];
  logic [7:0]  pat [MAX_PATTERN];
  logic [7:0]  rep [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq;

  logic [LW-1:0] fill_q, fill_d;
  bk_state_e     state_q, state_d;
  logic [31:0]   pos_q, pos_d, mcnt_q, mcnt_d, mcnt_inc;
  result_t       out_q;
  logic          ovalid_q;

  logic        adv, surplus, completes, hit, len_one;
  logic        emit, emit_start, emit_last;
  logic [7:0]  emit_byte;
  logic [31:0] emit_total;

  // Bytes past the sixteenth configured byte read as zero.
  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cfg_bytes
    if (g < CFG_BYTES) begin : g_in
      assign pat[g] = cfg_i.pattern[8*g +: 8];
      assign rep[g] = cfg_i.replacement[8*g +: 8];
    end else begin : g_out
      assign pat[g] = 8'h00;
      assign rep[g] = 8'h00;
    end
  end

  assign adv       = !ovalid_q || out_ready_i;
  assign surplus   = (fill_q >= len_i);
  assign completes = (({1'b0, fill_q} + 1'b1) == {1'b0, len_i});
  assign len_one   = (len_i == LW'(1));
  assign mcnt_inc  = (mcnt_q == 32'hFFFF_FFFF) ? mcnt_q : mcnt_q + 32'd1;

  // Window as it looks once the head byte is appended.
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      cand[i] = (fill_q == LW'(i)) ? head_item_i.data : win_q[i];
      eq[i]   = (LW'(i) >= len_i) || (cand[i] == pat[i]);
    end
  end

  assign hit = &eq;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      full[i] = (hit && cfg_i.replace_en) ? rep[i] : cand[i];
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
      sh_win[i]  = win_q[i+1];
      sh_full[i] = full[i+1];
    end
    sh_win[MAX_PATTERN-1]  = 8'h00;
    sh_full[MAX_PATTERN-1] = 8'h00;
  end

  always_comb begin
    win_d      = win_q;
    fill_d     = fill_q;
    state_d    = state_q;
    pop_o      = 1'b0;
    emit       = 1'b0;
    emit_byte  = win_q[0];
    emit_start = 1'b0;
    emit_last  = 1'b0;
    emit_total = mcnt_q;
    mcnt_d     = mcnt_q;
    pos_d      = pos_q;

    unique case (state_q)
      ST_RUN: begin
        if (head_valid_i && adv) begin
          if (surplus) begin
            // Window longer than the pattern after a length change.
            emit   = 1'b1;
            win_d  = sh_win;
            fill_d = fill_q - 1'b1;
          end else begin
            pop_o = 1'b1;
            if (completes) begin
              emit       = 1'b1;
              emit_byte  = full[0];
              emit_start = hit;
              emit_total = hit ? mcnt_inc : mcnt_q;
              mcnt_d     = emit_total;
              emit_last  = head_item_i.last && len_one;
              win_d      = sh_full;
              if (head_item_i.last && !len_one) begin
                state_d = ST_FLUSH;
              end
            end else begin
              win_d  = cand;
              fill_d = fill_q + 1'b1;
              if (head_item_i.last) begin
                state_d = ST_FLUSH;
              end
            end
          end
        end
      end
      ST_FLUSH: begin
        if (adv) begin
          emit      = 1'b1;
          emit_last = (fill_q == LW'(1));
          win_d     = sh_win;
          fill_d    = fill_q - 1'b1;
          if (emit_last) begin
            state_d = ST_RUN;
          end
        end
      end
      default: state_d = ST_RUN;
    endcase

    if (emit) begin
      if (emit_last) begin
        pos_d  = '0;
        mcnt_d = '0;
      end else begin
        pos_d = pos_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (emit) begin
      out_q.data     <= emit_byte;
      out_q.position <= pos_q;
      out_q.start    <= emit_start;
      out_q.total    <= emit_total;
      out_q.last     <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      state_q  <= ST_RUN;
      pos_q    <= '0;
      mcnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      state_q <= state_d;
      pos_q   <= pos_d;
      mcnt_q  <= mcnt_d;
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/byte_pattern_search_replace_core.sv
// A byte that completes the window passes the input queue and then the output register.
// Throughput: one byte per cycle in steady state while input is queued and the output
// accepts; the window compare is combinational. A final beat flushes every byte left in
// the window (at most one less than the pattern length). Beats after a pattern length
// shrink first drain the surplus, one byte per cycle while the output accepts.
// Reset (rst_ni low, asynchronous) empties queue and window and clears all counters.
`default_nettype none
`include "assert_macros.svh"

module byte_pattern_search_replace_core
  import bpsr_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration write port.
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_INDEX_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // Input stream.
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,   // data_byte
  input  wire logic                   s_axis_tlast,   // data_last
  // Output stream.
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [71:0]                 m_axis_tdata,   // out_byte, out_position, match_total
  output logic                        m_axis_tuser,   // match_start
  output logic                        m_axis_tlast    // out_last
);

  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);

  // The configuration registers. The pattern length is stored already
  // clamped to the range the window supports, so the engine never sees
  // zero or a length beyond its storage.
  logic [CFG_DATA_W-1:0] pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;
  logic                  rep_en_q;
  logic [LW-1:0]         len_q, len_wr;
  logic [4:0]            len_raw;

  assign len_raw = cfg_wdata_i[4:0];

  always_comb begin
    if (len_raw == 5'd0) begin
      len_wr = LW'(1);
    end else if (32'(len_raw) > MAX_PATTERN) begin
      len_wr = LW'(MAX_PATTERN);
    end else begin
      len_wr = LW'(len_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      rep_lo_q <= '0;
      rep_hi_q <= '0;
      len_q    <= LW'(1);
      rep_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_PATTERN_LOW:      pat_lo_q <= cfg_wdata_i;
        REG_PATTERN_HIGH:     pat_hi_q <= cfg_wdata_i;
        REG_REPLACEMENT_LOW:  rep_lo_q <= cfg_wdata_i;
        REG_REPLACEMENT_HIGH: rep_hi_q <= cfg_wdata_i;
        REG_PATTERN_LENGTH:   len_q    <= len_wr;
        REG_REPLACE_ENABLE:   rep_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  cfg_t cfg;
  assign cfg.pattern     = {pat_hi_q, pat_lo_q};
  assign cfg.replacement = {rep_hi_q, rep_lo_q};
  assign cfg.replace_en  = rep_en_q;

  // Front: every input beat is taken as long as the queue has room, so
  // the window engine stalling on the output never blocks the input
  // directly until the queue fills.
  item_t q_in, q_head;
  logic  q_full, q_valid, q_pop, q_push;

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && s_axis_tready;
  assign q_in.data     = s_axis_tdata;
  assign q_in.last     = s_axis_tlast;

  bpsr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_item_i  (q_in),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_valid),
    .head_item_o  (q_head)
  );

  // Back: the sliding window, compare, replace and flush sequencing. It
  // owns the output register that decouples it from the consumer.
  result_t res;

  bpsr_back #(
    .MAX_PATTERN (MAX_PATTERN),
    .LW          (LW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .len_i        (len_q),
    .head_valid_i (q_valid),
    .head_item_i  (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res)
  );

  assign m_axis_tdata = {res.total, res.position, res.data};
  assign m_axis_tuser = res.start;
  assign m_axis_tlast = res.last;

  // The stored length always lies inside the window's capacity.
  `ASSERT_ALWAYS(a_len_range, (len_q != '0) && (32'(len_q) <= MAX_PATTERN), "length out of range")

  // The engine only takes a beat that the queue actually holds.
  `ASSERT_IMPLIES(a_pop_valid, q_pop, q_valid, "pop from empty queue")

  // A beat that starts a match has been counted.
  `ASSERT_IMPLIES(a_start_counted, m_axis_tvalid && m_axis_tuser, m_axis_tdata[71:40] != 32'd0,
                  "match start with zero match total")

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the byte pattern search and replace core.
// A directed table runs first, then randomly built data frames that are
// mostly copies of the active pattern and replacement, mixed with noise.
// Every accepted input beat updates a local model of the window. The model
// queues the output beats that this input beat should release, and a monitor
// compares each output beat with the oldest queued one.
module testbench;
  import bpsr_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 24;     // queue, pipeline and a full flush
  localparam int unsigned RANDOM_BEATS  = 360;
  localparam int unsigned CALM_BEATS    = 60;     // the tail of the run has no idling
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // One output beat, split into its fields.
  typedef struct packed {
    logic [7:0]  data;
    logic [31:0] position;
    logic        start;
    logic [31:0] total;
    logic        last;
  } out_beat_t;

  // One row of the directed table: either a register write or an input beat.
  // An input beat may carry a hand-typed expectation that replaces the model's.
  typedef struct {
    bit          is_cfg;
    reg_index_e  idx;
    logic [63:0] value;
    logic [7:0]  data;
    logic        last;
    bit          typed;
    out_beat_t   want;
  } step_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = '0;   // data_byte
  logic                   s_axis_tlast = 1'b0; // data_last
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [71:0]            m_axis_tdata;        // out_byte, out_position, match_total
  logic                   m_axis_tuser;        // match_start
  logic                   m_axis_tlast;        // out_last

  byte_pattern_search_replace_core dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  always #10 clk_i = ~clk_i;

  // Local copy of the configuration, at its reset values.
  logic [63:0] pat_lo = '0;
  logic [63:0] pat_hi = '0;
  logic [63:0] rep_lo = '0;
  logic [63:0] rep_hi = '0;
  logic [4:0]  len_reg = 5'd1;
  logic        rep_en = 1'b0;

  // Local copy of the window and the counters.
  logic [7:0]  window_q [CFG_BYTES];
  int unsigned window_fill = 0;
  logic [31:0] pos_count = '0;
  logic [31:0] hit_count = '0;

  out_beat_t   pending_bytes [$];
  step_row_t   directed_rows [$];

  bit          idle_on = 1'b1;
  int unsigned errors = 0;
  int unsigned beats_sent = 0;
  int unsigned directed_beats = 0;
  int unsigned results_seen = 0;
  int unsigned starts_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;

  initial begin
    foreach (window_q[i]) window_q[i] = '0;
  end

  // A length of zero behaves as one, anything above the window size as the full window.
  function automatic int unsigned active_len();
    int unsigned l;
    l = len_reg;
    if (l == 0) l = 1;
    if (l > CFG_BYTES) l = CFG_BYTES;
    return l;
  endfunction

  function automatic logic [7:0] lane(input logic [63:0] lo, input logic [63:0] hi,
                                      input int unsigned i);
    if (i < 8) return lo[8*i +: 8];
    return hi[8*(i-8) +: 8];
  endfunction

  // Releases the oldest window byte as an output beat and shifts the window down.
  function automatic void shift_out(input logic start, input logic last);
    pending_bytes.push_back('{window_q[0], pos_count, start, hit_count, last});
    pos_count++;
    for (int unsigned i = 0; i + 1 < window_fill; i++) window_q[i] = window_q[i+1];
    if (window_fill > 0) window_fill--;
    window_q[window_fill] = '0;
  endfunction

  // Advances the window by one input byte and queues the output beats it releases.
  function automatic void scan_byte(input logic [7:0] value, input logic is_last);
    int unsigned l;
    bit          hit;
    l = active_len();
    if (window_fill < CFG_BYTES) begin
      window_q[window_fill] = value;
      window_fill++;
    end
    // After the length shrinks, the surplus oldest bytes leave unchecked.
    while (window_fill > l) shift_out(1'b0, is_last && window_fill == 1);
    if (window_fill == l) begin
      hit = 1'b1;
      for (int unsigned i = 0; i < l; i++) begin
        if (window_q[i] != lane(pat_lo, pat_hi, i)) hit = 1'b0;
      end
      if (hit) begin
        if (hit_count != '1) hit_count++;
        // Later compares see the replaced bytes.
        if (rep_en) begin
          for (int unsigned i = 0; i < l; i++) window_q[i] = lane(rep_lo, rep_hi, i);
        end
      end
      shift_out(hit, is_last && window_fill == 1);
    end
    // The final byte flushes the window and starts the next data afresh.
    if (is_last) begin
      while (window_fill > 0) shift_out(1'b0, window_fill == 1);
      pos_count = '0;
      hit_count = '0;
    end
  endfunction

  // Writes one register at the next edge and mirrors it locally. The write
  // enable is lowered by whatever the stimulus does next.
  task automatic program_reg(input reg_index_e idx, input logic [63:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_PATTERN_LOW:      pat_lo = value;
      REG_PATTERN_HIGH:     pat_hi = value;
      REG_REPLACEMENT_LOW:  rep_lo = value;
      REG_REPLACEMENT_HIGH: rep_hi = value;
      REG_PATTERN_LENGTH:   len_reg = value[4:0];
      REG_REPLACE_ENABLE:   rep_en = value[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Holds the sender off until every queued output beat has arrived, then lets the
  // block settle before it returns; bytes still filling the window stay in it.
  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    cfg_we_i      <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Offers one input beat, possibly after a gap, and waits for it to be taken.
  task automatic push_beat(input logic [7:0] value, input logic is_last,
                           input bit typed, input out_beat_t want);
    int unsigned gap;
    int unsigned queued;
    cfg_we_i <= 1'b0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= is_last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    queued = pending_bytes.size();
    scan_byte(value, is_last);
    // A hand-typed expectation stands in for whatever the model queued.
    if (typed) begin
      while (pending_bytes.size() > queued) void'(pending_bytes.pop_back());
      pending_bytes.push_back(want);
    end
    beats_sent++;
  endtask

  function automatic void add_cfg(input reg_index_e idx, input logic [63:0] value);
    directed_rows.push_back('{1'b1, idx, value, 8'h00, 1'b0, 1'b0, '0});
  endfunction

  function automatic void add_beat(input logic [7:0] value, input logic is_last,
                                   input bit typed = 1'b0, input out_beat_t want = '0);
    directed_rows.push_back('{1'b0, REG_PATTERN_LOW, '0, value, is_last, typed, want});
  endfunction

  // Extremes show up often; otherwise a fully random register value.
  function automatic logic [63:0] wide_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Pattern length with the out-of-range codes mixed in, and sometimes junk
  // in the unused upper bits.
  function automatic logic [63:0] length_value();
    logic [4:0] l;
    case ($urandom_range(0, 19))
      0:       l = 5'd0;
      1:       l = 5'd17;
      2:       l = 5'd31;
      3:       l = 5'd16;
      4, 5:    l = 5'($urandom_range(5, 15));
      default: l = 5'($urandom_range(1, 4));
    endcase
    if ($urandom_range(0, 3) == 0) return {{$urandom, $urandom} & ~64'h1F} | 64'(l);
    return 64'(l);
  endfunction

  // Receiver: ready drops for random bursts while idling is on.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Output monitor: each accepted beat is checked against the oldest expectation.
  always @(posedge clk_i) begin
    out_beat_t got;
    out_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[7:0], m_axis_tdata[39:8], m_axis_tuser, m_axis_tdata[71:40],
              m_axis_tlast};
      results_seen++;
      if (got.start === 1'b1) starts_seen++;
      if (pending_bytes.size() == 0) begin
        $error("output beat with nothing expected: byte %0h position %0d", got.data,
               got.position);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (got.data !== want.data) begin
          $error("out_byte expected %0h got %0h", want.data, got.data);
          errors++;
        end
        if (got.position !== want.position) begin
          $error("out_position expected %0d got %0d", want.position, got.position);
          errors++;
        end
        if (got.start !== want.start) begin
          $error("match_start expected %0b got %0b", want.start, got.start);
          errors++;
        end
        if (got.total !== want.total) begin
          $error("match_total expected %0d got %0d", want.total, got.total);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("out_last expected %0b got %0b", want.last, got.last);
          errors++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("byte_pattern_search_replace_core verification failed");
      $finish;
    end
  end

  initial begin
    logic [7:0]  frame_q [$];
    int unsigned random_beats;
    int unsigned frames;
    int unsigned target;
    int unsigned l;
    int unsigned cut;
    bit          open_end;

    // After reset the pattern is a single zero byte and replacing is off.
    add_beat(8'hFF, 1'b0, 1'b1, '{8'hFF, 32'd0, 1'b0, 32'd0, 1'b0});
    add_beat(8'h00, 1'b1, 1'b1, '{8'h00, 32'd1, 1'b1, 32'd1, 1'b1});
    // A zero length acts as one; counters start over after the final byte.
    add_cfg(REG_PATTERN_LENGTH, 64'd0);
    add_beat(8'h00, 1'b1, 1'b1, '{8'h00, 32'd0, 1'b1, 32'd1, 1'b1});
    add_beat(8'h5A, 1'b1, 1'b1, '{8'h5A, 32'd0, 1'b0, 32'd0, 1'b1});
    // Two-byte pattern 00 FF, search only.
    add_cfg(REG_PATTERN_LOW, 64'h0000_0000_0000_FF00);
    add_cfg(REG_PATTERN_LENGTH, 64'd2);
    add_beat(8'h00, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat(8'hFF, 1'b1);
    // Replace with 11 00: the written 00 joins the next FF in a fresh match.
    add_cfg(REG_REPLACEMENT_LOW, 64'h0000_0000_0000_0011);
    add_cfg(REG_REPLACE_ENABLE, 64'd1);
    add_beat(8'h00, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'hFF, 1'b1);
    // A length of 17 acts as the full window; data this short is flushed unchecked.
    add_cfg(REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg(REG_REPLACEMENT_HIGH, 64'h0123_4567_89AB_CDEF);
    add_cfg(REG_PATTERN_LENGTH, 64'd17);
    add_beat(8'hAA, 1'b0);
    add_beat(8'hBB, 1'b0);
    add_beat(8'hCC, 1'b1);
    // Fill part of a long window, then shrink the length to two mid-stream:
    // the next beat pushes the surplus bytes out unchecked first.
    add_beat(8'h01, 1'b0);
    add_beat(8'h02, 1'b0);
    add_beat(8'h03, 1'b0);
    add_beat(8'h04, 1'b0);
    add_beat(8'h05, 1'b0);
    add_cfg(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE2);
    add_beat(8'h00, 1'b0);
    add_beat(8'hFF, 1'b1);
    // Junk above bit 0 does not enable replacing; a length of 31 acts as 16.
    add_cfg(REG_REPLACE_ENABLE, 64'hFFFF_FFFF_FFFF_FFFE);
    add_cfg(REG_PATTERN_LENGTH, 64'd31);
    add_beat(8'h00, 1'b1, 1'b1, '{8'h00, 32'd0, 1'b0, 32'd0, 1'b1});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        drain_and_settle();
        program_reg(directed_rows[r].idx, directed_rows[r].value);
      end else begin
        push_beat(directed_rows[r].data, directed_rows[r].last, directed_rows[r].typed,
                  directed_rows[r].want);
      end
    end
    directed_beats = beats_sent;

    // Random phases. Each one waits for the block to go quiet, rewrites some
    // registers and sends a few frames built mostly from pattern copies, so
    // that matches, overlapping matches and replaced bytes come up often.
    random_beats = 0;
    while (random_beats < RANDOM_BEATS) begin
      drain_and_settle();
      idle_on = (random_beats + CALM_BEATS < RANDOM_BEATS) ? ($urandom_range(0, 3) != 0)
                                                           : 1'b0;
      if ($urandom_range(0, 2) == 0) program_reg(REG_PATTERN_LOW, wide_value());
      if ($urandom_range(0, 3) == 0) program_reg(REG_PATTERN_HIGH, wide_value());
      if ($urandom_range(0, 2) == 0) program_reg(REG_REPLACEMENT_LOW, wide_value());
      if ($urandom_range(0, 3) == 0) program_reg(REG_REPLACEMENT_HIGH, wide_value());
      if ($urandom_range(0, 1) == 0) program_reg(REG_PATTERN_LENGTH, length_value());
      if ($urandom_range(0, 2) == 0) begin
        program_reg(REG_REPLACE_ENABLE, ($urandom_range(0, 3) == 0) ? wide_value()
                                                                    : 64'($urandom_range(0, 1)));
      end

      l = active_len();
      frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++) begin
        frame_q.delete();
        target = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        while (frame_q.size() < target) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: for (int unsigned i = 0; i < l; i++) frame_q.push_back(lane(pat_lo, pat_hi, i));
            4: begin
              cut = $urandom_range(1, l);
              for (int unsigned i = 0; i < cut; i++) frame_q.push_back(lane(pat_lo, pat_hi, i));
            end
            5: for (int unsigned i = 0; i < l; i++) frame_q.push_back(lane(rep_lo, rep_hi, i));
            6: frame_q.push_back(lane(pat_lo, pat_hi, $urandom_range(0, l - 1)));
            default: frame_q.push_back(8'($urandom_range(0, 255)));
          endcase
        end
        // Now and then the phase ends mid-frame, so the next settings meet a
        // partly filled window.
        open_end = (f == frames - 1) && ($urandom_range(0, 3) == 0);
        foreach (frame_q[i]) begin
          push_beat(frame_q[i], (i == frame_q.size() - 1) && !open_end, 1'b0, '0);
        end
        random_beats += frame_q.size();
      end
    end

    // Close any open frame so the window empties, then wait for the tail.
    push_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
    drain_and_settle();

    $display("Sent %0d input beats (%0d from the directed table) over %0d register writes.",
             beats_sent, directed_beats, reg_writes);
    $display("Checked %0d output beats, %0d of them flagged as match starts.",
             results_seen, starts_seen);
    if (errors == 0) begin
      $display("byte_pattern_search_replace_core verification clean");
    end else begin
      $display("byte_pattern_search_replace_core verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/bpsr_pkg.sv
hw/rtl/bpsr_queue.sv
hw/rtl/bpsr_back.sv
hw/rtl/byte_pattern_search_replace_core.sv
dv/testbench.sv
